// ----- rtl/core/utf8d_pkg.sv -----
// utf8d_pkg: shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int CP_W           = 21;
    localparam int UTF8D_FIFO_DEPTH = 4;

    // byte classes of a utf-8 stream
    localparam logic [7:0] BYTE_ASCII_LO = 8'h00;
    localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
    localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hC0;
    localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
    localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
    localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
    localparam logic [7:0] BYTE_LEAD4_HI = 8'hF7;

    // continuation bytes still expected after each lead
    localparam logic [1:0] REM_NONE  = 2'd0;
    localparam logic [1:0] REM_LEAD2 = 2'd1;
    localparam logic [1:0] REM_LEAD3 = 2'd2;
    localparam logic [1:0] REM_LEAD4 = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_string;
    } in_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_item;
    } out_beat_t;

    // decoder state
    typedef struct packed {
        logic [CP_W-1:0] partial_value;
        logic [1:0]      bytes_remaining;
    } dec_state_t;

    // results of one byte, packed from slot 0 upward
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  slot1;
        out_beat_t  slot0;
    } dec_results_t;

endpackage

// ----- rtl/core/utf8d_decode.sv -----
// utf8d_decode: per-byte state update and result generation
`timescale 1ns / 1ps

module utf8d_decode
    import utf8d_pkg::*;
(
    input  dec_state_t   state,
    input  in_beat_t     beat,
    output dec_state_t   state_next,
    output dec_results_t results
);

    logic [CP_W-1:0] shifted;
    out_beat_t       char_beat;
    out_beat_t       term_beat;
    logic            char_out;

    assign shifted   = {state.partial_value[CP_W-7:0], beat.text_byte[5:0]};
    assign term_beat = '{code_point: '0, last_item: 1'b1};

    always_comb
    begin
        state_next = state;
        char_beat  = '{code_point: '0, last_item: 1'b0};
        char_out   = 1'b0;

        unique case (beat.text_byte) inside
            [BYTE_ASCII_LO:BYTE_ASCII_HI]:
            begin
                state_next = '0;
                char_beat  = '{code_point: CP_W'(beat.text_byte), last_item: 1'b0};
                char_out   = 1'b1;
            end
            [BYTE_CONT_LO:BYTE_CONT_HI]:
            begin
                // stray continuation bytes leave the state alone
                if (state.bytes_remaining != REM_NONE)
                begin
                    state_next.bytes_remaining = state.bytes_remaining - 2'd1;
                    state_next.partial_value   = shifted;
                    if (state.bytes_remaining == REM_LEAD2)
                    begin
                        char_beat  = '{code_point: shifted, last_item: 1'b0};
                        char_out   = 1'b1;
                        state_next.partial_value = '0;
                    end
                end
            end
            [BYTE_LEAD2_LO:BYTE_LEAD2_HI]:
            begin
                state_next.partial_value   = CP_W'(beat.text_byte[4:0]);
                state_next.bytes_remaining = REM_LEAD2;
            end
            [BYTE_LEAD3_LO:BYTE_LEAD3_HI]:
            begin
                state_next.partial_value   = CP_W'(beat.text_byte[3:0]);
                state_next.bytes_remaining = REM_LEAD3;
            end
            [BYTE_LEAD4_LO:BYTE_LEAD4_HI]:
            begin
                state_next.partial_value   = CP_W'(beat.text_byte[2:0]);
                state_next.bytes_remaining = REM_LEAD4;
            end
            default:
            begin
                // invalid lead
                state_next = '0;
            end
        endcase

        if (beat.end_of_string)
        begin
            state_next = '0;
        end
    end

    always_comb
    begin
        results.count = {1'b0, char_out} + {1'b0, beat.end_of_string};
        results.slot0 = char_out ? char_beat : term_beat;
        results.slot1 = term_beat;
    end

endmodule

// ----- rtl/core/utf8d_fifo.sv -----
// utf8d_fifo: result queue taking up to two beats per cycle, one out
`timescale 1ns / 1ps

module utf8d_fifo
    import utf8d_pkg::*;
#(
    parameter int DEPTH = UTF8D_FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dec_results_t push,
    output logic         space_ok,
    output logic         head_valid,
    output out_beat_t    head,
    input  logic         pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    out_beat_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   wr_ptr_plus1;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
            r = '0;
        else
            r = p + AW'(1);
        return r;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign space_ok     = (count_reg <= CW'(DEPTH - 2));
    assign head_valid   = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.count == 2'd1)
            wr_ptr_next = wr_ptr_plus1;
        else if (push.count == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.slot0;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.slot1;
    end

endmodule

// ----- rtl/core/utf8_stream_decoder_core.sv -----
// utf8_stream_decoder_core: utf-8 byte stream to code point decoder, top level
//
//  channel | dir | payload    | handshake
//  --------+-----+------------+-----------------------------------
//  in      | in  | in_beat_t  | in_valid / in_ready, one byte per beat
//  out     | out | out_beat_t | out_valid / out_ready, one code point per beat
//
// one byte is taken per cycle while in_ready is high; a byte yielding a result
// shows it on out the next cycle at the earliest
// a byte that yields two beats (a character and the terminator) sends them one
// after the other, so the sustained rate is set by the single output port
// in_ready drops when the result queue has fewer than two free entries
// reset clears the decoder state and the queue; nothing needs a clearing pass
// stalls on out only reach in_ready once fewer than two queue entries are free
`timescale 1ns / 1ps

module utf8_stream_decoder_core
    import utf8d_pkg::*;
#(
    parameter int FIFO_DEPTH = UTF8D_FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    dec_state_t   state_reg;
    dec_state_t   state_next;
    dec_state_t   dec_state;
    dec_results_t dec_res;
    dec_results_t push;
    logic         in_fire;
    logic         space_ok;

    assign in_ready = space_ok;
    assign in_fire  = in_valid && space_ok;

    // decode the incoming byte against the current sequence state
    utf8d_decode u_decode (
        .state      (state_reg),
        .beat       (in_data),
        .state_next (dec_state),
        .results    (dec_res)
    );

    always_comb
    begin
        state_next = in_fire ? dec_state : state_reg;
        push       = dec_res;
        if (!in_fire)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    // result queue doubles as the output register
    utf8d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (out_valid),
        .head       (out_data),
        .pop        (out_valid && out_ready)
    );

endmodule

// ----- rtl/core/utf8d_checker.sv -----
// utf8d_checker: port-level assertions for the utf-8 stream decoder
`timescale 1ns / 1ps

module utf8d_checker
    import utf8d_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // backpressure on in only comes from pending results
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no pending result");

    // an ascii byte into an empty decoder comes straight out
    a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && !in_data.text_byte[7]
        |=> out_valid && !out_data.last_item
            && out_data.code_point == CP_W'($past(in_data.text_byte)))
        else $error("ascii byte not passed through");

    // a lead or invalid byte marked end of string gives only the terminator
    a_term_after_lead: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && in_data.end_of_string
        && in_data.text_byte[7] && in_data.text_byte[6]
        |=> out_valid && out_data.last_item && out_data.code_point == '0)
        else $error("terminator missing after end of string");

    // the terminator always carries a zero code point
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_item |-> out_data.code_point == '0)
        else $error("terminator with nonzero code point");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker (.*);
